// ===== rtl/bezier_patch_height_lookup_macros.svh =====
// Assertion macros for the bezier patch height lookup block.
// Used by the checker file; depends on nothing else.
`ifndef BEZIER_PATCH_HEIGHT_LOOKUP_MACROS_SVH
`define BEZIER_PATCH_HEIGHT_LOOKUP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BPH_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the condition.
`define BPH_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// ===== rtl/bph_pkg.sv =====
// Package of the bezier patch height lookup block: constants and types.
// Used by the weight unit, the map memory and the top level; depends on nothing.
`default_nettype none
package bph_pkg;
    localparam int MAX_SIDE    = 256;
    localparam int FRAC_BITS   = 8;
    localparam int PATCH_CELLS = 4;
    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int T_BITS = FRAC_BITS + 2;
    localparam int W_BITS = FRAC_BITS + 8;
    localparam int TV_W   = T_BITS + 3;      // t reaches 2.0 when the patch is clamped
    localparam int WGT_W  = 24;              // signed weight width; weights stay within +-32
    localparam int ACC_W  = 56;              // total of five rows of weighted row sums
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WGT, ST_READ, ST_ROW, ST_DONE
    } t_state;

    typedef struct packed {
        logic             wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_req;
endpackage
`default_nettype wire

// ===== rtl/bph_weights.sv =====
// Degree-4 Bernstein weight unit: one weight per cycle, multiplies registered.
// Depends on bph_pkg.
`default_nettype none
module bph_weights (
    input  wire logic                            i_clk,
    input  wire logic                            i_start,
    input  wire logic signed [bph_pkg::TV_W:0]   i_t,
    output logic                                 o_done,
    output logic signed [bph_pkg::WGT_W-1:0]     o_w [5]
);
    import bph_pkg::*;

    localparam int PW = 2 * TV_W + 3;
    logic signed [TV_W+1:0] r_t, r_a;
    logic signed [PW-1:0]   r_t2, r_a2, r_ta;
    logic [2:0]             r_step;
    logic                   r_run;
    logic signed [2*PW+3:0] n_prod;
    logic signed [2*PW-1:0] n_mul;
    logic signed [PW-1:0]   n_l, n_r;
    logic signed [3:0]      n_k;

    always_comb begin
        n_l = r_t2;
        n_r = r_a2;
        n_k = 4'sd1;
        case (r_step)
            3'd1: begin n_l = r_a2; n_r = r_a2; n_k = 4'sd1; end
            3'd2: begin n_l = r_ta; n_r = r_a2; n_k = 4'sd4; end
            3'd3: begin n_l = r_t2; n_r = r_a2; n_k = 4'sd6; end
            3'd4: begin n_l = r_t2; n_r = r_ta; n_k = 4'sd4; end
            default: begin n_l = r_t2; n_r = r_t2; n_k = 4'sd1; end
        endcase
        n_mul  = n_l * n_r;
        n_prod = n_mul * n_k;
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (i_start) begin
            r_t    <= {i_t[TV_W], i_t};
            r_a    <= $signed((TV_W+2)'(1 << T_BITS)) - {i_t[TV_W], i_t};
            r_step <= 3'd0;
            r_run  <= 1'b1;
        end else if (r_run) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd0) begin
                r_t2 <= PW'(r_t * r_t);
                r_a2 <= PW'(r_a * r_a);
                r_ta <= PW'(r_t * r_a);
            end else begin
                o_w[r_step - 3'd1] <= WGT_W'(n_prod >>> (4 * T_BITS - W_BITS));
            end
            if (r_step == 3'd5) begin
                r_run  <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bph_map_ram.sv =====
// Height map: one read and up to one write a cycle, registered read data.
// Depends on bph_pkg.
`default_nettype none
module bph_map_ram (
    input  wire logic              i_clk,
    input  wire bph_pkg::t_mem_req i_req,
    output logic [7:0]             o_rdata
);
    import bph_pkg::*;

    logic [7:0] r_mem [MAX_SIDE*MAX_SIDE];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.data;
        end
        o_rdata <= r_mem[i_req.addr];
    end
endmodule
`default_nettype wire

// ===== rtl/bezier_patch_height_lookup.sv =====
// Top level of the bezier patch height lookup block: control and blending.
// Depends on bph_pkg, bph_map_ram and bph_weights.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------------
//  command   | start / busy            | i_op, i_row, i_column, i_sample, i_query_x/z
//  result    | o_valid strobe          | o_height, o_in_range
//  config    | i_cfg_valid/o_cfg_ready | i_cfg_data (map_side)
//
// A sample write gives no result and never raises busy. A query outside the
// map goes from idle straight to the done state, which strobes its result.
// An inside query first runs the two weight units side by side, then per patch
// row makes 5 map memory reads, drains the read data and folds the row into
// the total, and finally scales the total down and saturates it in the done
// state.
// Reset is synchronous, active low, and clears control state and map_side to 256.
// The result receiver cannot stall, so each result is shown for one cycle only.
`default_nettype none
module bezier_patch_height_lookup (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_row,
    input  wire logic [7:0]  i_column,
    input  wire logic [7:0]  i_sample,
    input  wire logic signed [16:0] i_query_x,
    input  wire logic signed [16:0] i_query_z,
    output logic             o_valid,
    output logic [15:0]      o_height,
    output logic             o_in_range,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [8:0]  i_cfg_data
);
    import bph_pkg::*;

    t_state r_state, n_state;
    logic [8:0] r_side;
    logic [8:0] n_len;
    logic [8:0] n_half, n_last;
    logic signed [18:0] n_lim, n_fx, n_fz;
    logic n_out;
    logic [IDX_W-1:0] r_sx, r_sz;
    logic signed [TV_W:0] r_tu, r_tv;
    logic [2:0] r_i, r_j, r_ri;
    logic r_rd_pend;
    logic signed [WGT_W-1:0] wu [5];
    logic signed [WGT_W-1:0] wv [5];
    logic u_done, v_done, r_wstart;
    logic signed [WGT_W+10:0] r_rowsum;
    logic signed [ACC_W-1:0] r_total;
    logic signed [ACC_W-1:0] n_tot_out;
    logic [7:0] rdata;
    t_mem_req mreq;
    logic accept;
    logic [9:0] n_sx, n_sz;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !start;

    // Clamp the side length, range-check the query, find its patch origin.
    always_comb begin
        n_len = r_side;
        if (r_side < 9'd5) n_len = 9'd5;
        if (r_side > 9'(MAX_SIDE)) n_len = 9'(MAX_SIDE);
        n_half = n_len >> 1;
        n_last = 9'((((n_len - 9'd1) >> 2) - 9'd1) << 2);
        n_lim  = 19'(n_half) <<< FRAC_BITS;
        n_out  = (19'(i_query_x) < -n_lim) || (19'(i_query_x) > n_lim) ||
                 (19'(i_query_z) < -n_lim) || (19'(i_query_z) > n_lim);
        n_fx   = 19'(i_query_x) + n_lim;
        n_fz   = 19'(i_query_z) + n_lim;
        n_sx   = {n_fx[17:FRAC_BITS+2], 2'b00};
        n_sz   = {n_fz[17:FRAC_BITS+2], 2'b00};
        if (n_sx > 10'(n_last)) n_sx = 10'(n_last);
        if (n_sz > 10'(n_last)) n_sz = 10'(n_last);
    end

    // Memory requests: writes in idle, reads while walking the patch.
    always_comb begin
        mreq.wr_en = accept && (i_op == OP_WRITE);
        mreq.data  = i_sample;
        mreq.addr  = {i_row, i_column};
        if (r_state == ST_READ) begin
            mreq.addr = {IDX_W'(r_sz + IDX_W'(r_j)), IDX_W'(r_sx + IDX_W'(r_i))};
        end
    end

    bph_map_ram u_ram (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));
    bph_weights u_wu (.i_clk(i_clk), .i_start(r_wstart), .i_t(r_tu),
                      .o_done(u_done), .o_w(wu));
    bph_weights u_wv (.i_clk(i_clk), .i_start(r_wstart), .i_t(r_tv),
                      .o_done(v_done), .o_w(wv));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept && i_op == OP_QUERY) n_state = n_out ? ST_DONE : ST_WGT;
            ST_WGT:  if (u_done && v_done) n_state = ST_READ;
            ST_READ: if (r_i == 3'd4) n_state = ST_ROW;
            ST_ROW:  if (!r_rd_pend) n_state = (r_j == 3'd4) ? ST_DONE : ST_READ;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_tot_out = r_total >>> (2 * W_BITS - FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_side    <= 9'(MAX_SIDE);
            o_valid   <= 1'b0;
            r_wstart  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wstart <= 1'b0;
            o_valid  <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_side <= i_cfg_data;
            r_rd_pend <= (r_state == ST_READ);
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_op == OP_QUERY) begin
                        r_sx <= IDX_W'(n_sx);
                        r_sz <= IDX_W'(n_sz);
                        r_tu <= (TV_W+1)'(n_fx - (19'(n_sx) <<< FRAC_BITS));
                        r_tv <= (TV_W+1)'(n_fz - (19'(n_sz) <<< FRAC_BITS));
                        r_wstart <= !n_out;
                        r_total  <= '0;
                        r_j <= 3'd0;
                        r_i <= 3'd0;
                        o_in_range <= !n_out;
                    end
                end
                ST_WGT: begin
                    r_rowsum <= '0;
                    r_ri <= 3'd0;
                end
                ST_READ: begin
                    r_i <= r_i + 3'd1;
                end
                ST_ROW: begin
                    if (!r_rd_pend) begin
                        r_total  <= r_total + ACC_W'(wv[r_j] * r_rowsum);
                        r_rowsum <= '0;
                        r_ri <= 3'd0;
                        r_i  <= 3'd0;
                        r_j  <= r_j + 3'd1;
                    end
                end
                ST_DONE: begin
                    o_valid <= 1'b1;
                    if (!o_in_range || n_tot_out < 0) o_height <= 16'd0;
                    else if (n_tot_out > 65535) o_height <= 16'hFFFF;
                    else o_height <= 16'(n_tot_out);
                end
                default: ;
            endcase
            if (r_rd_pend) begin
                r_rowsum <= r_rowsum + (WGT_W+11)'(wu[r_ri] * $signed({1'b0, rdata}));
                r_ri <= r_ri + 3'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bph_checker.sv =====
// Port-level checker for the bezier patch height lookup block, bound to the top.
// Depends on the assertion macros header.
`default_nettype none
`include "bezier_patch_height_lookup_macros.svh"
module bph_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [15:0] o_height,
    input wire logic        o_in_range,
    input wire logic        o_cfg_ready
);
    `BPH_ASSERT_IMP(a_out_zero, i_clk, i_rst_n, o_valid && !o_in_range, o_height == 16'd0, "outside query gave nonzero height")
    `BPH_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, !busy, "config ready while busy")
    `BPH_ASSERT_NXT(a_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than a cycle")
endmodule
bind bezier_patch_height_lookup bph_checker u_chk (.*);
`default_nettype wire
